@@ src/brob_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap raster-op blitter package
// Shared widths, codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package brob_pkg;

    // Store geometry and field widths.
    localparam int STORE_WORDS = 65536;
    localparam int STORE_AW    = 16;
    localparam int WORD_W      = 16;
    localparam int COORD_W     = 12;
    localparam int CLIP_W      = 16;
    localparam int DIM_W       = 11;
    localparam int REG_IDX_W   = 2;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 24;

    // Default geometry of the bitmap in the store.
    localparam int DEF_WORDS_PER_ROW = 64;
    localparam int DEF_ROW_COUNT     = 1024;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BLIT  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_BITMAP_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BITMAP_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0]     DIM_RESET         = 11'd1024;

    // Functions that never look at the source.
    localparam logic [3:0] FN_ZERO  = 4'h0;
    localparam logic [3:0] FN_NOT_D = 4'h5;
    localparam logic [3:0] FN_DEST  = 4'ha;
    localparam logic [3:0] FN_ONES  = 4'hf;

    // Clipping steps.
    localparam logic [2:0] CLIP_FLIP     = 3'd0;
    localparam logic [2:0] CLIP_DEST_NEG = 3'd1;
    localparam logic [2:0] CLIP_SRC_NEG  = 3'd2;
    localparam logic [2:0] CLIP_SRC_FAR  = 3'd3;
    localparam logic [2:0] CLIP_DEST_FAR = 3'd4;

    // Read address selection.
    localparam logic [1:0] RD_WORD = 2'd0;
    localparam logic [1:0] RD_DEST = 2'd1;
    localparam logic [1:0] RD_SRC0 = 2'd2;
    localparam logic [1:0] RD_SRC1 = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clip_en;
        logic [2:0] clip_step;
        logic       setup;
        logic       base;
        logic [1:0] rd_sel;
        logic       we;
        logic       wr_blit;
        logic       cap_d;
        logic       cap_s0;
        logic       step;
        logic       res_read;
        logic       res_empty;
        logic       out_load;
    } brob_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       src;
        logic       shift;
        logic       empty_rect;
        logic       no_change;
        logic       last;
        logic       out_free;
    } brob_stat_t;

endpackage

`default_nettype wire

@@ src/brob_ctrl.sv @@
// ----------------------------------------------------------------------------
// Blitter controller
// State machine that sequences word accesses, clipping, setup and the
// per-word read-modify-write walk of a blit.
// ----------------------------------------------------------------------------
`default_nettype none

module brob_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire brob_pkg::brob_stat_t stat,
    output brob_pkg::brob_cmd_t     cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_WRITE     = 5'd1;
    localparam logic [4:0] S_READ      = 5'd2;
    localparam logic [4:0] S_READ_WAIT = 5'd3;
    localparam logic [4:0] S_CLIP_FLIP = 5'd4;
    localparam logic [4:0] S_CLIP_DNEG = 5'd5;
    localparam logic [4:0] S_CLIP_SNEG = 5'd6;
    localparam logic [4:0] S_CLIP_SFAR = 5'd7;
    localparam logic [4:0] S_CLIP_DFAR = 5'd8;
    localparam logic [4:0] S_CHECK     = 5'd9;
    localparam logic [4:0] S_SETUP     = 5'd10;
    localparam logic [4:0] S_BASE      = 5'd11;
    localparam logic [4:0] S_RD_D      = 5'd12;
    localparam logic [4:0] S_RD_S0     = 5'd13;
    localparam logic [4:0] S_RD_S1     = 5'd14;
    localparam logic [4:0] S_CALC      = 5'd15;
    localparam logic [4:0] S_FINISH    = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    unique case (stat.op)
                        brob_pkg::OP_WRITE: state_next = S_WRITE;
                        brob_pkg::OP_READ:  state_next = S_READ;
                        brob_pkg::OP_BLIT:  state_next = S_CLIP_FLIP;
                        default:            state_next = S_FINISH;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.we     = 1'b1;
                state_next = S_FINISH;
            end
            S_READ:
            begin
                cmd.rd_sel = brob_pkg::RD_WORD;
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                cmd.res_read = 1'b1;
                state_next   = S_FINISH;
            end
            S_CLIP_FLIP:
            begin
                cmd.clip_en   = 1'b1;
                cmd.clip_step = brob_pkg::CLIP_FLIP;
                state_next    = S_CLIP_DNEG;
            end
            S_CLIP_DNEG:
            begin
                cmd.clip_en   = 1'b1;
                cmd.clip_step = brob_pkg::CLIP_DEST_NEG;
                state_next    = S_CLIP_SNEG;
            end
            S_CLIP_SNEG:
            begin
                cmd.clip_en   = 1'b1;
                cmd.clip_step = brob_pkg::CLIP_SRC_NEG;
                state_next    = S_CLIP_SFAR;
            end
            S_CLIP_SFAR:
            begin
                cmd.clip_en   = 1'b1;
                cmd.clip_step = brob_pkg::CLIP_SRC_FAR;
                state_next    = S_CLIP_DFAR;
            end
            S_CLIP_DFAR:
            begin
                cmd.clip_en   = 1'b1;
                cmd.clip_step = brob_pkg::CLIP_DEST_FAR;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.empty_rect || stat.no_change)
                begin
                    cmd.res_empty = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = S_RD_D;
            end
            S_RD_D:
            begin
                cmd.rd_sel = brob_pkg::RD_DEST;
                state_next = stat.src ? S_RD_S0 : S_CALC;
            end
            S_RD_S0:
            begin
                cmd.cap_d  = 1'b1;
                cmd.rd_sel = brob_pkg::RD_SRC0;
                state_next = stat.shift ? S_RD_S1 : S_CALC;
            end
            S_RD_S1:
            begin
                cmd.cap_s0 = 1'b1;
                cmd.rd_sel = brob_pkg::RD_SRC1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.we      = 1'b1;
                cmd.wr_blit = 1'b1;
                cmd.step    = 1'b1;
                state_next  = stat.last ? S_FINISH : S_RD_D;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/brob_dp.sv @@
// ----------------------------------------------------------------------------
// Blitter datapath
// Frame store, configuration registers, clipping and setup registers,
// address generation, the raster function and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module brob_dp #(
    parameter int WORDS_PER_ROW = brob_pkg::DEF_WORDS_PER_ROW,
    parameter int ROW_COUNT     = brob_pkg::DEF_ROW_COUNT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [1:0]                        s_tuser,
    input  wire logic [brob_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [brob_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [brob_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [brob_pkg::DIM_W-1:0]        cfg_data,
    input  wire brob_pkg::brob_cmd_t               cmd,
    output brob_pkg::brob_stat_t                   stat
);

    localparam int W   = brob_pkg::WORD_W;
    localparam int CW  = brob_pkg::CLIP_W;
    localparam int DW  = brob_pkg::DIM_W;
    localparam int AW  = brob_pkg::STORE_AW;
    localparam int ADDR_W = DW + $clog2(WORDS_PER_ROW) + 3;
    localparam int LIMIT  = (ROW_COUNT * WORDS_PER_ROW < brob_pkg::STORE_WORDS) ?
                            ROW_COUNT * WORDS_PER_ROW : brob_pkg::STORE_WORDS;
    localparam logic signed [ADDR_W-1:0] LIMIT_S = ADDR_W'(LIMIT);
    localparam logic signed [ADDR_W-1:0] ROW_STEP = ADDR_W'(WORDS_PER_ROW);

    // Input fields.
    logic [AW-1:0]                 in_addr;
    logic [W-1:0]                  in_wdata;
    logic [brob_pkg::COORD_W-1:0]  in_dx, in_dy, in_wd, in_ht, in_sx, in_sy;
    logic [3:0]                    in_fc;
    logic                          in_use_src;

    assign in_addr    = s_tdata[15:0];
    assign in_wdata   = s_tdata[31:16];
    assign in_dx      = s_tdata[43:32];
    assign in_dy      = s_tdata[55:44];
    assign in_wd      = s_tdata[67:56];
    assign in_ht      = s_tdata[79:68];
    assign in_fc      = s_tdata[83:80];
    assign in_sx      = s_tdata[95:84];
    assign in_sy      = s_tdata[107:96];
    assign in_use_src = s_tdata[108];

    // Configuration registers.
    logic [DW-1:0] bw_reg, bh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= brob_pkg::DIM_RESET;
            bh_reg <= brob_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == brob_pkg::REG_BITMAP_WIDTH)
            begin
                bw_reg <= cfg_data;
            end
            if (cfg_index == brob_pkg::REG_BITMAP_HEIGHT)
            begin
                bh_reg <= cfg_data;
            end
        end
    end

    // Latched operation and rectangle.
    logic [AW-1:0]        addr_reg;
    logic [W-1:0]         wdata_reg;
    logic signed [CW-1:0] xd_reg, yd_reg, wd_reg, ht_reg, xs_reg, ys_reg;
    logic signed [CW-1:0] xd_next, yd_next, wd_next, ht_next, xs_next, ys_next;
    logic [3:0]           f_reg, f_load;
    logic                 src_reg, src_load;
    logic signed [CW-1:0] bw_s, bh_s, over_x, over_y;

    assign bw_s = CW'($signed({1'b0, bw_reg}));
    assign bh_s = CW'($signed({1'b0, bh_reg}));

    // Without a source the function collapses to its destination-only form.
    always_comb
    begin
        if (!in_use_src)
        begin
            f_load   = {in_fc[3:2], in_fc[3:2]};
            src_load = 1'b0;
        end
        else
        begin
            f_load   = in_fc;
            src_load = !(in_fc == brob_pkg::FN_ZERO || in_fc == brob_pkg::FN_NOT_D ||
                         in_fc == brob_pkg::FN_DEST || in_fc == brob_pkg::FN_ONES);
        end
    end

    // One clipping step per cycle on the rectangle registers.
    always_comb
    begin
        xd_next = xd_reg;
        yd_next = yd_reg;
        wd_next = wd_reg;
        ht_next = ht_reg;
        xs_next = xs_reg;
        ys_next = ys_reg;
        over_x  = '0;
        over_y  = '0;
        unique case (cmd.clip_step)
            brob_pkg::CLIP_FLIP:
            begin
                if (wd_reg < 0)
                begin
                    xd_next = xd_reg + wd_reg;
                    wd_next = -wd_reg;
                end
                if (ht_reg < 0)
                begin
                    yd_next = yd_reg + ht_reg;
                    ht_next = -ht_reg;
                end
            end
            brob_pkg::CLIP_DEST_NEG:
            begin
                if (xd_reg < 0)
                begin
                    if (src_reg)
                    begin
                        xs_next = xs_reg - xd_reg;
                    end
                    wd_next = wd_reg + xd_reg;
                    xd_next = '0;
                end
                if (yd_reg < 0)
                begin
                    if (src_reg)
                    begin
                        ys_next = ys_reg - yd_reg;
                    end
                    ht_next = ht_reg + yd_reg;
                    yd_next = '0;
                end
            end
            brob_pkg::CLIP_SRC_NEG:
            begin
                if (src_reg && xs_reg < 0)
                begin
                    xd_next = xd_reg - xs_reg;
                    wd_next = wd_reg + xs_reg;
                    xs_next = '0;
                end
                if (src_reg && ys_reg < 0)
                begin
                    yd_next = yd_reg - ys_reg;
                    ht_next = ht_reg + ys_reg;
                    ys_next = '0;
                end
            end
            brob_pkg::CLIP_SRC_FAR:
            begin
                over_x = xs_reg + wd_reg - bw_s;
                over_y = ys_reg + ht_reg - bh_s;
                if (src_reg && over_x > 0)
                begin
                    wd_next = wd_reg - over_x;
                end
                if (src_reg && over_y > 0)
                begin
                    ht_next = ht_reg - over_y;
                end
            end
            brob_pkg::CLIP_DEST_FAR:
            begin
                over_x = xd_reg + wd_reg - bw_s;
                over_y = yd_reg + ht_reg - bh_s;
                if (over_x > 0)
                begin
                    wd_next = wd_reg - over_x;
                end
                if (over_y > 0)
                begin
                    ht_next = ht_reg - over_y;
                end
            end
            default:
            begin
                xd_next = xd_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg  <= in_addr;
            wdata_reg <= in_wdata;
            xd_reg    <= CW'($signed(in_dx));
            yd_reg    <= CW'($signed(in_dy));
            wd_reg    <= CW'($signed(in_wd));
            ht_reg    <= CW'($signed(in_ht));
            xs_reg    <= CW'($signed(in_sx));
            ys_reg    <= CW'($signed(in_sy));
            f_reg     <= f_load;
            src_reg   <= src_load;
        end
        else if (cmd.clip_en)
        begin
            xd_reg <= xd_next;
            yd_reg <= yd_next;
            wd_reg <= wd_next;
            ht_reg <= ht_next;
            xs_reg <= xs_next;
            ys_reg <= ys_next;
        end
    end

    // Function masks, one bit each, replicated across the word later.
    logic k_bit, a_bit, b_bit, c_bit;

    assign k_bit = f_reg[0];
    assign a_bit = f_reg[0] ^ f_reg[1];
    assign b_bit = f_reg[0] ^ f_reg[2];
    assign c_bit = ^f_reg;

    // Setup of word span, edge masks, alignment and walk direction.
    logic signed [CW-1:0] end_x, ro0;
    logic [7:0]           dxw_c, ex_c, nw_c;
    logic [W-1:0]         lm_c, rm_c;
    logic signed [4:0]    diff_c;
    logic                 up_c, rev_c;
    logic [7:0]           dxw_reg, nw_reg, w_reg, w_first, w_end;
    logic signed [8:0]    sxw_reg;
    logic [W-1:0]         lm_reg, rm_reg;
    logic [3:0]           lsh_reg;
    logic                 up_reg, rev_reg;
    logic [DW-1:0]        dr0_reg, sr0_reg, r_reg;
    logic signed [CW-1:0] dr0_c, sr0_c;

    assign end_x  = xd_reg + wd_reg - CW'(1);
    assign dxw_c  = xd_reg[11:4];
    assign ex_c   = end_x[11:4];
    assign nw_c   = ex_c - dxw_c + 8'd1;
    assign diff_c = $signed({1'b0, xs_reg[3:0]}) - $signed({1'b0, xd_reg[3:0]});
    assign up_c   = src_reg && (yd_reg > ys_reg);
    assign rev_c  = src_reg && (xd_reg > xs_reg);
    assign ro0    = up_c ? ht_reg - CW'(1) : '0;
    assign dr0_c  = yd_reg + ro0;
    assign sr0_c  = ys_reg + ro0;

    always_comb
    begin
        lm_c = 16'hffff >> xd_reg[3:0];
        rm_c = 16'hffff << (4'd15 - end_x[3:0]);
        if (ex_c == dxw_c)
        begin
            lm_c = lm_c & rm_c;
            rm_c = lm_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            dxw_reg <= dxw_c;
            nw_reg  <= nw_c;
            lm_reg  <= lm_c;
            rm_reg  <= rm_c;
            lsh_reg <= diff_c[3:0];
            sxw_reg <= $signed({1'b0, xs_reg[11:4]}) - ((diff_c < 0) ? 9'sd1 : 9'sd0);
            up_reg  <= up_c;
            rev_reg <= rev_c;
            dr0_reg <= dr0_c[DW-1:0];
            sr0_reg <= sr0_c[DW-1:0];
        end
    end

    // Row base addresses and word walk.
    logic signed [ADDR_W-1:0] dbase_reg, sbase_reg, row_step;
    logic                     last_word;

    assign w_first   = rev_reg ? nw_reg - 8'd1 : 8'd0;
    assign w_end     = rev_reg ? 8'd0 : nw_reg - 8'd1;
    assign last_word = (w_reg == w_end);
    assign row_step  = up_reg ? -ROW_STEP : ROW_STEP;

    always_ff @(posedge clk)
    begin
        if (cmd.base)
        begin
            dbase_reg <= $signed(ADDR_W'(dr0_reg)) * ROW_STEP;
            sbase_reg <= $signed(ADDR_W'(sr0_reg)) * ROW_STEP;
            w_reg     <= w_first;
            r_reg     <= '0;
        end
        else if (cmd.step)
        begin
            if (last_word)
            begin
                w_reg     <= w_first;
                r_reg     <= r_reg + DW'(1);
                dbase_reg <= dbase_reg + row_step;
                sbase_reg <= sbase_reg + row_step;
            end
            else
            begin
                w_reg <= rev_reg ? w_reg - 8'd1 : w_reg + 8'd1;
            end
        end
    end

    // Store addresses and their bounds.
    logic signed [ADDR_W-1:0] a_d, a_s0, a_s1;
    logic                     ok_d, ok_s0, ok_s1;

    assign a_d   = dbase_reg + $signed(ADDR_W'(dxw_reg)) + $signed(ADDR_W'(w_reg));
    assign a_s0  = sbase_reg + ADDR_W'(sxw_reg) + $signed(ADDR_W'(w_reg));
    assign a_s1  = a_s0 + $signed(ADDR_W'(1));
    assign ok_d  = (a_d >= 0) && (a_d < LIMIT_S);
    assign ok_s0 = (a_s0 >= 0) && (a_s0 < LIMIT_S);
    assign ok_s1 = (a_s1 >= 0) && (a_s1 < LIMIT_S);

    logic [AW-1:0] raddr;
    logic          rok;

    always_comb
    begin
        unique case (cmd.rd_sel)
            brob_pkg::RD_WORD:
            begin
                raddr = addr_reg;
                rok   = 1'b1;
            end
            brob_pkg::RD_DEST:
            begin
                raddr = a_d[AW-1:0];
                rok   = ok_d;
            end
            brob_pkg::RD_SRC0:
            begin
                raddr = a_s0[AW-1:0];
                rok   = ok_s0;
            end
            default:
            begin
                raddr = a_s1[AW-1:0];
                rok   = ok_s1;
            end
        endcase
    end

    // Raster function and edge merge.
    logic [W-1:0]   rdata_reg, rdata_f, d_reg, s0_reg, d_w, s_w, res_w, mask_w, merged;
    logic [2*W-1:0] pair_sh;
    logic           rok_reg;

    assign rdata_f = rok_reg ? rdata_reg : '0;
    assign pair_sh = {s0_reg, rdata_f} << lsh_reg;
    assign d_w     = src_reg ? d_reg : rdata_f;
    assign s_w     = !src_reg ? '0 : ((lsh_reg != 4'd0) ? pair_sh[2*W-1:W] : rdata_f);
    assign res_w   = {W{k_bit}} ^ (d_w & {W{a_bit}}) ^ (s_w & {W{b_bit}}) ^
                     (d_w & s_w & {W{c_bit}});
    assign mask_w  = (w_reg == 8'd0) ? lm_reg :
                     ((w_reg == nw_reg - 8'd1) ? rm_reg : 16'hffff);
    assign merged  = (d_w & ~mask_w) | (res_w & mask_w);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_d)
        begin
            d_reg <= rdata_f;
        end
        if (cmd.cap_s0)
        begin
            s0_reg <= rdata_f;
        end
    end

    // Frame store with registered read.
    logic [W-1:0] mem [brob_pkg::STORE_WORDS];

    always_ff @(posedge clk)
    begin
        if (cmd.we && !cmd.wr_blit)
        begin
            mem[addr_reg] <= wdata_reg;
        end
        else if (cmd.we && ok_d)
        begin
            mem[a_d[AW-1:0]] <= merged;
        end
        rdata_reg <= mem[raddr];
        rok_reg   <= rok;
    end

    // Result and output word register.
    logic [W-1:0] res_word_reg, out_word_reg;
    logic         res_empty_reg, out_empty_reg, m_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_word_reg  <= '0;
            res_empty_reg <= 1'b0;
        end
        else
        begin
            if (cmd.res_read)
            begin
                res_word_reg <= rdata_f;
            end
            if (cmd.res_empty)
            begin
                res_empty_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_word_reg  <= res_word_reg;
            out_empty_reg <= res_empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_empty_reg, out_word_reg};

    // Status back to the controller.
    assign stat.op         = s_tuser;
    assign stat.src        = src_reg;
    assign stat.shift      = (lsh_reg != 4'd0);
    assign stat.empty_rect = (wd_reg < 1) || (ht_reg < 1);
    assign stat.no_change  = !src_reg && a_bit && !k_bit;
    assign stat.last       = last_word && (r_reg == ht_reg[DW-1:0] - DW'(1));
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

@@ src/bitmap_raster_op_blitter.sv @@
// Word write: store write, then the result word. Word read: store read, then the read word.
// Blit: clipping, the empty check, setup and row base, then for each covered store
// word a destination read, no, one or two source reads, and a write on the single store port.
// Throughput: one item at a time; the next item is taken after the result is loaded.
// Reset: control and bitmap size registers reset (size 1024 x 1024); the frame
// store has no reset and holds whatever was written.
// ----------------------------------------------------------------------------
// Bitmap raster-op blitter
// Monochrome frame store with word access and 16-function block transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_raster_op_blitter #(
    parameter int WORDS_PER_ROW = brob_pkg::DEF_WORDS_PER_ROW,
    parameter int ROW_COUNT     = brob_pkg::DEF_ROW_COUNT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // op
    input  wire logic [1:0]                     s_tuser,
    // word_address, write_word, dest_x, dest_y, rect_width, rect_height,
    // function_code, source_x, source_y, use_source, zero fill
    input  wire logic [brob_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // read_word, clipped_empty, zero fill
    output logic [brob_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [brob_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [brob_pkg::DIM_W-1:0]     cfg_data
);

    brob_pkg::brob_cmd_t  cmd;
    brob_pkg::brob_stat_t stat;

    // Sequencer.
    brob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store and datapath.
    brob_dp #(
        .WORDS_PER_ROW (WORDS_PER_ROW),
        .ROW_COUNT     (ROW_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef ASSERT_OFF
    // An accepted word makes the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // A read result never reports an empty blit.
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && (m_tdata[15:0] != 16'd0)))
        else $error("read word and empty flag both set");

    // A new result only appears while an item is in progress.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared with no item in progress");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Bitmap raster-op blitter testbench
// Fills a small corner of the frame store, then runs word writes, word reads
// and blits under several bitmap sizes and handshake idling patterns. A
// predictor of the store and of the blit arithmetic computes each result
// word, and a checker compares every accepted result with the oldest
// prediction. Blits are only sent when every store word they read has been
// written before.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WPR         = brob_pkg::DEF_WORDS_PER_ROW;
    localparam int ROWS        = brob_pkg::DEF_ROW_COUNT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int FILL_ROWS   = 16;
    localparam int FILL_COLS   = 5;

    typedef struct {
        logic [1:0]         op;
        logic [15:0]        addr;
        logic [15:0]        wdata;
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic signed [11:0] rw;
        logic signed [11:0] rh;
        logic [3:0]         fc;
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic               us;
    } blt_item_t;

    typedef struct {
        logic [15:0] rd;
        logic        empty;
    } blt_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [1:0]                      s_tuser = '0;
    logic [brob_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [brob_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we = 1'b0;
    logic [brob_pkg::REG_IDX_W-1:0]  cfg_index = '0;
    logic [brob_pkg::DIM_W-1:0]      cfg_data = '0;

    // Predictor state: store image, written marks and bitmap size.
    logic [15:0] store_image [brob_pkg::STORE_WORDS];
    bit          written [brob_pkg::STORE_WORDS];
    int          written_list[$];
    int          bm_width;
    int          bm_height;
    logic        dry_run = 1'b0;
    logic        fetch_unwritten = 1'b0;

    blt_result_t pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    bitmap_raster_op_blitter #(
        .WORDS_PER_ROW(WPR),
        .ROW_COUNT(ROWS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result word with the oldest prediction.
    always @(posedge clk)
    begin
        blt_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no prediction waiting: %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_res.rd)
                begin
                    $error("read_word: expected %h, got %h", exp_res.rd, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[16] !== exp_res.empty)
                begin
                    $error("clipped_empty: expected %b, got %b", exp_res.empty, m_tdata[16]);
                    error_count++;
                end
            end
        end
    end

    function automatic void mark_written(int a);
        if (!written[a])
        begin
            written[a] = 1'b1;
            written_list.push_back(a);
        end
    endfunction

    function automatic logic [15:0] pixel_fetch(int row, int col);
        int a;
        a = row * WPR + col;
        if (a < 0 || a >= WPR * ROWS || a >= brob_pkg::STORE_WORDS)
            return 16'h0;
        if (!written[a])
            fetch_unwritten = 1'b1;
        return store_image[a];
    endfunction

    function automatic void pixel_put(int row, int col, logic [15:0] v);
        int a;
        a = row * WPR + col;
        if (dry_run || a < 0 || a >= WPR * ROWS || a >= brob_pkg::STORE_WORDS)
            return;
        store_image[a] = v;
        mark_written(a);
    endfunction

    // Blit on the store image; returns 1 when nothing was changed.
    function automatic logic raster_blit(blt_item_t it);
        int          xd, yd, wd, ht, xs, ys, ov, dxw, sxw, nw, ro, wi, dr, sr;
        int          lsh, rsh;
        logic [3:0]  f;
        logic        src, up, rev;
        logic [15:0] mk, ma, mb, mc, lm, rm, m, d, s, res;
        xd = it.dx; yd = it.dy; wd = it.rw; ht = it.rh; xs = it.sx; ys = it.sy;
        f = it.fc; src = it.us;
        lsh = 0; rsh = 0; sxw = 0; up = 1'b0; rev = 1'b0;
        // Without a source, keep the function's dependence on the destination.
        if (!src)
        begin
            case (f[3:2])
                2'd0: f = brob_pkg::FN_ZERO;
                2'd1: f = brob_pkg::FN_NOT_D;
                2'd2: f = brob_pkg::FN_DEST;
                default: f = brob_pkg::FN_ONES;
            endcase
        end
        else if (f == brob_pkg::FN_ZERO || f == brob_pkg::FN_NOT_D ||
                 f == brob_pkg::FN_DEST || f == brob_pkg::FN_ONES)
            src = 1'b0;
        // Negative sizes flip the origin, then clip to the bitmap.
        if (wd < 0) begin xd += wd; wd = -wd; end
        if (ht < 0) begin yd += ht; ht = -ht; end
        if (xd < 0) begin if (src) xs -= xd; wd += xd; xd = 0; end
        if (yd < 0) begin if (src) ys -= yd; ht += yd; yd = 0; end
        if (src)
        begin
            if (xs < 0) begin xd -= xs; wd += xs; xs = 0; end
            if (ys < 0) begin yd -= ys; ht += ys; ys = 0; end
            ov = xs + wd - bm_width;
            if (ov > 0) wd -= ov;
            ov = ys + ht - bm_height;
            if (ov > 0) ht -= ov;
        end
        ov = xd + wd - bm_width;
        if (ov > 0) wd -= ov;
        ov = yd + ht - bm_height;
        if (ov > 0) ht -= ov;
        if (wd < 1 || ht < 1)
            return 1'b1;
        mk = {16{f[0]}};
        ma = {16{f[0] ^ f[1]}};
        mb = {16{f[0] ^ f[2]}};
        mc = {16{^f}};
        if (!src && ma != 16'h0 && mk == 16'h0)
            return 1'b1;
        // Edge masks and source alignment.
        dxw = xd >>> 4;
        nw = ((xd + wd - 1) >>> 4) - dxw + 1;
        lm = 16'hffff >> (xd & 15);
        rm = 16'hffff << (15 - ((xd + wd - 1) & 15));
        if (nw < 2)
        begin
            lm = lm & rm;
            rm = lm;
        end
        if (src)
        begin
            sxw = xs >>> 4;
            ov = (xs & 15) - (xd & 15);
            if (ov > 0)
            begin
                lsh = ov; rsh = 16 - ov;
            end
            else if (ov < 0)
            begin
                rsh = -ov; lsh = 16 + ov; sxw -= 1;
            end
            up = yd > ys;
            rev = xd > xs;
        end
        for (int r = 0; r < ht; r++)
        begin
            ro = up ? ht - 1 - r : r;
            dr = yd + ro;
            sr = ys + ro;
            for (int k = 0; k < nw; k++)
            begin
                wi = rev ? nw - 1 - k : k;
                m = (wi == 0) ? lm : ((wi == nw - 1) ? rm : 16'hffff);
                d = pixel_fetch(dr, dxw + wi);
                s = 16'h0;
                if (src)
                begin
                    if (lsh == 0)
                        s = pixel_fetch(sr, sxw + wi);
                    else
                        s = (pixel_fetch(sr, sxw + wi) << lsh)
                            | (pixel_fetch(sr, sxw + wi + 1) >> rsh);
                end
                res = mk ^ (d & ma) ^ (s & mb) ^ (d & s & mc);
                pixel_put(dr, dxw + wi, (d & ~m) | (res & m));
            end
        end
        return 1'b0;
    endfunction

    // Walks a blit without changing the image; true when it reads only written words.
    function automatic logic blit_is_safe(blt_item_t it);
        logic unused_empty;
        dry_run = 1'b1;
        fetch_unwritten = 1'b0;
        unused_empty = raster_blit(it);
        dry_run = 1'b0;
        return !fetch_unwritten;
    endfunction

    function automatic blt_result_t predict_result(blt_item_t it);
        blt_result_t res;
        res.rd = 16'h0;
        res.empty = 1'b0;
        case (it.op)
            brob_pkg::OP_WRITE:
            begin
                store_image[it.addr] = it.wdata;
                mark_written(int'(it.addr));
            end
            brob_pkg::OP_READ:  res.rd = store_image[it.addr];
            brob_pkg::OP_BLIT:  res.empty = raster_blit(it);
            default:  ;
        endcase
        return res;
    endfunction

    // Send one word; predict its result once it is accepted.
    task automatic send_item(blt_item_t it);
        logic accepted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {3'b000, it.us, it.sy, it.sx, it.fc, it.rh, it.rw, it.dy, it.dx,
                    it.wdata, it.addr};
        do
        begin
            @(posedge clk);
            accepted = s_tvalid && s_tready;
        end
        while (!accepted);
        pending_results.push_back(predict_result(it));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Register write with the block idle.
    task automatic write_register(logic [brob_pkg::REG_IDX_W-1:0] idx, int value);
        drain_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[brob_pkg::DIM_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == brob_pkg::REG_BITMAP_WIDTH)
            bm_width = value & 32'h7ff;
        else if (idx == brob_pkg::REG_BITMAP_HEIGHT)
            bm_height = value & 32'h7ff;
    endtask

    task automatic set_bitmap(int w, int h);
        write_register(brob_pkg::REG_BITMAP_WIDTH, w);
        write_register(brob_pkg::REG_BITMAP_HEIGHT, h);
    endtask

    function automatic blt_item_t word_item(logic [1:0] op, logic [15:0] a, logic [15:0] v);
        blt_item_t it;
        it = '{op: op, addr: a, wdata: v, dx: '0, dy: '0, rw: '0, rh: '0, fc: '0,
               sx: '0, sy: '0, us: 1'b0};
        return it;
    endfunction

    function automatic blt_item_t blit_item(int x, int y, int w, int h, logic [3:0] f,
                                            int ssx, int ssy, logic u);
        blt_item_t it;
        it = word_item(brob_pkg::OP_BLIT, 16'($urandom), 16'($urandom));
        it.dx = 12'(x); it.dy = 12'(y); it.rw = 12'(w); it.rh = 12'(h); it.fc = f;
        it.sx = 12'(ssx); it.sy = 12'(ssy); it.us = u;
        return it;
    endfunction

    function automatic blt_item_t read_item();
        int idx;
        idx = $urandom_range(written_list.size() - 1);
        return word_item(brob_pkg::OP_READ, 16'(written_list[idx]), 16'($urandom));
    endfunction

    // Blits that would read an unwritten word are left out.
    task automatic send_blit(blt_item_t it);
        if (blit_is_safe(it))
            send_item(it);
    endtask

    // Give the top-left corner of the store, and the last word of each of its
    // rows, a known value so that blits there never read garbage.
    task automatic test_store_fill();
        for (int r = 0; r < FILL_ROWS; r++)
        begin
            for (int c = 0; c < FILL_COLS; c++)
                send_item(word_item(brob_pkg::OP_WRITE, 16'(r * WPR + c), 16'($urandom)));
            send_item(word_item(brob_pkg::OP_WRITE, 16'(r * WPR + WPR - 1), 16'($urandom)));
        end
    endtask

    task automatic test_word_access();
        send_item(word_item(brob_pkg::OP_WRITE, 16'h0000, 16'hffff));
        send_item(word_item(brob_pkg::OP_WRITE, 16'hffff, 16'h0000));
        send_item(word_item(brob_pkg::OP_READ, 16'h0000, 16'h0));
        send_item(word_item(brob_pkg::OP_READ, 16'hffff, 16'hffff));
        send_item(word_item(brob_pkg::OP_NONE, 16'hffff, 16'hffff));
        send_item(word_item(brob_pkg::OP_WRITE, 16'hffff, 16'ha5c3));
        send_item(word_item(brob_pkg::OP_READ, 16'hffff, 16'h0));
    endtask

    task automatic test_blit_directed();
        // Every function with a source, then the no-source remaps.
        for (int f = 0; f < 16; f++)
            send_blit(blit_item(5 + f, 3, 37, 4, 4'(f), 40, 9, 1'b1));
        send_blit(blit_item(30, 10, 20, 3, brob_pkg::FN_DEST, 0, 0, 1'b0));
        send_blit(blit_item(30, 10, 20, 3, 4'h6, 0, 0, 1'b0));
        // Negative sizes, and overlap walking in both directions.
        send_blit(blit_item(60, 20, -25, -6, 4'hc, 3, 2, 1'b1));
        send_blit(blit_item(20, 12, 50, 7, 4'hc, 13, 9, 1'b1));
        send_blit(blit_item(13, 9, 50, 7, 4'h6, 20, 12, 1'b1));
        // Extremes of the coordinate fields, mostly clipped away.
        send_blit(blit_item(-2048, -2048, 2047, 2047, 4'hc, 2047, 2047, 1'b1));
        send_blit(blit_item(2047, 2047, -2048, -2048, 4'h3, -2048, -2048, 1'b1));
        send_blit(blit_item(-2048, 2047, 2047, -2048, 4'h9, 0, 0, 1'b1));
        send_blit(blit_item(100, 100, 0, 5, 4'hc, 0, 0, 1'b1));
    endtask

    function automatic int rand_between(int lo, int hi);
        return lo + $urandom_range(hi - lo);
    endfunction

    // Random mix; blits mostly land near the filled corner with small sizes.
    task automatic test_random(int count, int w, int h, int s_idle, int r_stall);
        blt_item_t it;
        int        sel, x, y, tries, xspan, yspan;
        logic      wild, found;
        set_bitmap(w, h);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        wild = (w <= 64 && h <= FILL_ROWS);
        xspan = (w < 64) ? w : 64;
        yspan = (h < FILL_ROWS) ? h : FILL_ROWS;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 20)
                it = word_item(brob_pkg::OP_WRITE, 16'($urandom), 16'($urandom));
            else if (sel < 35)
                it = read_item();
            else if (sel < 40)
                it = word_item(brob_pkg::OP_NONE, 16'($urandom), 16'($urandom));
            else
            begin
                found = 1'b0;
                tries = 0;
                while (!found && tries < 50)
                begin
                    if (wild && sel < 60)
                    begin
                        it = blit_item($urandom, $urandom, $urandom, $urandom,
                                       4'($urandom), $urandom, $urandom, 1'($urandom));
                    end
                    else
                    begin
                        x = rand_between(-20, xspan + 4);
                        y = rand_between(-6, yspan + 2);
                        it = blit_item(x, y, rand_between(-40, 40), rand_between(-8, 8),
                                       4'($urandom), x + rand_between(-24, 24),
                                       y + rand_between(-6, 6),
                                       ($urandom_range(9) != 0));
                    end
                    found = blit_is_safe(it);
                    tries++;
                end
                if (!found)
                    it = read_item();
            end
            send_item(it);
        end
        drain_results();
    endtask

    initial
    begin
        bm_width = brob_pkg::DIM_RESET;
        bm_height = brob_pkg::DIM_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_store_fill();
        test_word_access();
        set_bitmap(48, 16);
        test_blit_directed();
        // An index past the two registers must change nothing.
        write_register(2'd3, 5);
        test_random(55, 1024, 1024, 0, 0);
        test_random(55, 40, 12, 53, 0);
        test_random(55, 64, 1, 0, 53);
        test_random(55, 1, 16, 18, 18);
        test_random(55, 1, 1, 0, 0);
        test_random(55, 1000, 700, 18, 18);

        drain_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
